// ===== hw/rtl/dld_pkg.sv =====
// Package for the Damerau-Levenshtein distance block.
// It holds the sizes, the word types, the controller state type and the control bundles.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package dld_pkg;
   localparam int MAX_LEN       = 64;
   localparam int ALPHABET_SIZE = 256;
   localparam int CHAR_W        = 8;
   localparam int SYM_W         = $clog2(ALPHABET_SIZE);
   localparam int LEN_W         = $clog2(MAX_LEN + 1);
   localparam int IDX_W         = $clog2(MAX_LEN);
   localparam int CELL_W        = $clog2(2 * MAX_LEN + 1);
   localparam int CALC_W        = CELL_W + 2;
   localparam int MAT_AW        = 2 * IDX_W;
   localparam int MAT_DEPTH     = MAX_LEN * MAX_LEN;

   localparam logic [1:0] FUNC_APPEND_A = 2'd0;
   localparam logic [1:0] FUNC_APPEND_B = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE  = 2'd2;

   typedef struct packed {
      logic [1:0]        func;
      logic [CHAR_W-1:0] ch;
   } req_type;

   typedef struct packed {
      logic [7:0] distance;
      logic       overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROWA,
      ST_STR,
      ST_ROW,
      ST_MAT,
      ST_CAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic append_a;
      logic append_b;
      logic start;
      logic row_start;
      logic rd_str;
      logic rd_row;
      logic rd_mat;
      logic calc;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic col_end;
      logic row_end;
      logic rsp_busy;
   } sts_type;
endpackage
`default_nettype wire

// ===== hw/rtl/dld_ram.sv =====
// Generic single write port memory with one registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module dld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/dld_ctrl.sv =====
// Controller state machine of the distance block: it sequences appends and the cell walk.
// It depends on dld_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dld_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [1:0]      req_func,
   input  wire dld_pkg::sts_type sts,
   output dld_pkg::cmd_type     cmd,
   output logic                 req_stall
);
   dld_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dld_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dld_pkg::ST_IDLE: begin
            if (req_valid && req_func == dld_pkg::FUNC_COMPUTE) begin
               state_in = sts.empty ? dld_pkg::ST_DONE : dld_pkg::ST_ROWA;
            end
         end
         dld_pkg::ST_ROWA: state_in = dld_pkg::ST_STR;
         dld_pkg::ST_STR:  state_in = dld_pkg::ST_ROW;
         dld_pkg::ST_ROW:  state_in = dld_pkg::ST_MAT;
         dld_pkg::ST_MAT:  state_in = dld_pkg::ST_CAL;
         dld_pkg::ST_CAL: begin
            if (!sts.col_end) begin
               state_in = dld_pkg::ST_STR;
            end else if (sts.row_end) begin
               state_in = dld_pkg::ST_DONE;
            end else begin
               state_in = dld_pkg::ST_ROWA;
            end
         end
         dld_pkg::ST_DONE: begin
            if (!sts.rsp_busy) begin
               state_in = dld_pkg::ST_IDLE;
            end
         end
         default: state_in = dld_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         dld_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.append_a = req_valid && req_func == dld_pkg::FUNC_APPEND_A;
            cmd.append_b = req_valid && req_func == dld_pkg::FUNC_APPEND_B;
            cmd.start    = req_valid && req_func == dld_pkg::FUNC_COMPUTE;
         end
         dld_pkg::ST_ROWA: cmd.row_start = 1'b1;
         dld_pkg::ST_STR:  cmd.rd_str    = 1'b1;
         dld_pkg::ST_ROW:  cmd.rd_row    = 1'b1;
         dld_pkg::ST_MAT:  cmd.rd_mat    = 1'b1;
         dld_pkg::ST_CAL:  cmd.calc      = 1'b1;
         dld_pkg::ST_DONE: cmd.publish   = !sts.rsp_busy;
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== hw/rtl/dld_datapath.sv =====
// Datapath of the distance block: strings, last row table, distance matrix and cell arithmetic.
// It depends on dld_pkg and dld_ram.
`timescale 1ns / 1ps
`default_nettype none
module dld_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dld_pkg::req_type  req_data,
   input  wire dld_pkg::cmd_type  cmd,
   output dld_pkg::sts_type      sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dld_pkg::rsp_type      rsp_data
);
   localparam int LW = dld_pkg::LEN_W;
   localparam int IW = dld_pkg::IDX_W;
   localparam int CW = dld_pkg::CELL_W;
   localparam int KW = dld_pkg::CALC_W;
   localparam int SW = dld_pkg::SYM_W;
   localparam int HW = dld_pkg::CHAR_W;

   logic [LW-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic          drop_ff, drop_in;
   logic [LW-1:0] i_ff, i_in, j_ff, j_in;
   logic [LW-1:0] last_col_ff, last_col_in, r1_ff, r1_in;
   logic [CW-1:0] diag_ff, diag_in, left_ff, left_in, result_ff, result_in;
   logic [dld_pkg::ALPHABET_SIZE-1:0] lr_valid_ff, lr_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   dld_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [HW-1:0] a_rd, b_rd, sym_in;
   logic [LW-1:0] lr_rd, r1_now;
   logic [CW-1:0] mat_a_rd, mat_b_rd, maxv, up_val, trans_base, best_cell;
   logic [KW-1:0] sub_v, ins_v, del_v, trans_v, best;
   logic          full_a, full_b, match, row_done;

   assign sym_in = HW'(req_data.ch[SW-1:0]);
   assign full_a = len_a_ff == LW'(dld_pkg::MAX_LEN);
   assign full_b = len_b_ff == LW'(dld_pkg::MAX_LEN);
   assign match  = a_rd == b_rd;
   assign maxv   = CW'(len_a_ff) + CW'(len_b_ff);
   assign row_done = cmd.calc && sts.col_end;

   dld_ram #(.WIDTH(HW), .DEPTH(dld_pkg::MAX_LEN)) u_str_a (
      .clock(clock), .wr_en(cmd.append_a && !full_a), .wr_addr(IW'(len_a_ff)),
      .wr_data(sym_in), .rd_en(cmd.row_start), .rd_addr(IW'(i_ff - LW'(1))),
      .rd_data(a_rd)
   );

   dld_ram #(.WIDTH(HW), .DEPTH(dld_pkg::MAX_LEN)) u_str_b (
      .clock(clock), .wr_en(cmd.append_b && !full_b), .wr_addr(IW'(len_b_ff)),
      .wr_data(sym_in), .rd_en(cmd.rd_str), .rd_addr(IW'(j_ff - LW'(1))),
      .rd_data(b_rd)
   );

   dld_ram #(.WIDTH(LW), .DEPTH(dld_pkg::ALPHABET_SIZE)) u_last_row (
      .clock(clock), .wr_en(row_done), .wr_addr(a_rd[SW-1:0]), .wr_data(i_ff),
      .rd_en(cmd.rd_row), .rd_addr(b_rd[SW-1:0]), .rd_data(lr_rd)
   );

   dld_ram #(.WIDTH(CW), .DEPTH(dld_pkg::MAT_DEPTH)) u_mat_up (
      .clock(clock), .wr_en(cmd.calc),
      .wr_addr({IW'(i_ff - LW'(1)), IW'(j_ff - LW'(1))}), .wr_data(best_cell),
      .rd_en(cmd.rd_row), .rd_addr({IW'(i_ff - LW'(2)), IW'(j_ff - LW'(1))}),
      .rd_data(mat_a_rd)
   );

   dld_ram #(.WIDTH(CW), .DEPTH(dld_pkg::MAT_DEPTH)) u_mat_trans (
      .clock(clock), .wr_en(cmd.calc),
      .wr_addr({IW'(i_ff - LW'(1)), IW'(j_ff - LW'(1))}), .wr_data(best_cell),
      .rd_en(cmd.rd_mat), .rd_addr({IW'(r1_now - LW'(2)), IW'(last_col_ff - LW'(2))}),
      .rd_data(mat_b_rd)
   );

   always_comb begin
      r1_now = lr_valid_ff[b_rd[SW-1:0]] ? lr_rd : '0;
      up_val = (i_ff == LW'(1)) ? CW'(j_ff) : mat_a_rd;
      if (r1_ff == '0 || last_col_ff == '0) begin
         trans_base = maxv;
      end else if (r1_ff == LW'(1)) begin
         trans_base = CW'(last_col_ff - LW'(1));
      end else if (last_col_ff == LW'(1)) begin
         trans_base = CW'(r1_ff - LW'(1));
      end else begin
         trans_base = mat_b_rd;
      end
      sub_v   = KW'(diag_ff) + (match ? KW'(0) : KW'(1));
      ins_v   = KW'(left_ff) + KW'(1);
      del_v   = KW'(up_val) + KW'(1);
      trans_v = KW'(trans_base) + KW'(i_ff) - KW'(r1_ff) + KW'(j_ff)
                - KW'(last_col_ff) - KW'(1);
      best = sub_v;
      if (ins_v < best) begin
         best = ins_v;
      end
      if (del_v < best) begin
         best = del_v;
      end
      if (trans_v < best) begin
         best = trans_v;
      end
      best_cell = CW'(best);
   end

   always_comb begin
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      drop_in      = drop_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      last_col_in  = last_col_ff;
      r1_in        = r1_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      result_in    = result_ff;
      lr_valid_in  = lr_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.append_a) begin
         if (full_a) begin
            drop_in = 1'b1;
         end else begin
            len_a_in = len_a_ff + LW'(1);
         end
      end
      if (cmd.append_b) begin
         if (full_b) begin
            drop_in = 1'b1;
         end else begin
            len_b_in = len_b_ff + LW'(1);
         end
      end
      if (cmd.start) begin
         i_in      = LW'(1);
         j_in      = LW'(1);
         result_in = maxv;
      end
      if (cmd.row_start) begin
         diag_in     = CW'(i_ff - LW'(1));
         left_in     = CW'(i_ff);
         last_col_in = '0;
      end
      if (cmd.rd_mat) begin
         r1_in = r1_now;
      end
      if (cmd.calc) begin
         left_in   = best_cell;
         diag_in   = up_val;
         result_in = best_cell;
         if (match) begin
            last_col_in = j_ff;
         end
         if (sts.col_end) begin
            j_in = LW'(1);
            i_in = i_ff + LW'(1);
            lr_valid_in[a_rd[SW-1:0]] = 1'b1;
         end else begin
            j_in = j_ff + LW'(1);
         end
      end
      if (cmd.publish) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.distance = 8'(result_ff);
         rsp_data_in.overflow = drop_ff;
         len_a_in             = '0;
         len_b_in             = '0;
         drop_in              = 1'b0;
         lr_valid_in          = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         drop_ff      <= 1'b0;
         lr_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         drop_ff      <= drop_in;
         lr_valid_ff  <= lr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      last_col_ff <= last_col_in;
      r1_ff       <= r1_in;
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.empty    = len_a_ff == '0 || len_b_ff == '0;
   assign sts.col_end  = j_ff == len_b_ff;
   assign sts.row_end  = i_ff == len_a_ff;
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/damerau_levenshtein_distance.sv =====
// Top level of the Damerau-Levenshtein distance block.
// It depends on dld_pkg, dld_ctrl and dld_datapath.
//
// Usage. Request words carry func and ch. A func 0 or 1 word appends ch to the
// first or second string; a character beyond 64 is dropped and flagged. A
// func 2 word computes the unrestricted distance and returns one response
// word with distance and overflow, then clears both strings.
// Sequence. With lengths la and lb both nonzero each row opens with a read
// of the first string, and each matrix cell then takes registered reads
// through the second string, the last-row table and the matrix memories
// before its arithmetic. With an empty string the controller goes straight
// to the done state and returns the response word.
// Request stall stays high for the whole compute and until the response
// register can be loaded. Appends are taken while a response waits.
// Reset clears the lengths, the overflow flag and the table marks at once;
// no clearing pass is needed. A stalled response holds its word.
`timescale 1ns / 1ps
`default_nettype none
module damerau_levenshtein_distance (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dld_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dld_pkg::rsp_type      rsp_data
);
   dld_pkg::cmd_type cmd;
   dld_pkg::sts_type sts;

   dld_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_func(req_data.func),
      .sts(sts), .cmd(cmd), .req_stall(req_stall)
   );

   dld_datapath u_datapath (
      .clock(clock), .reset(reset), .req_data(req_data), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_compute_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.func == dld_pkg::FUNC_COMPUTE) |=> req_stall)
      else $error("compute word did not stall the request channel");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared outside a compute");

   a_distance_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.distance <= 8'(2 * dld_pkg::MAX_LEN))
      else $error("distance beyond the sum of the maximum lengths");
`endif
endmodule
`default_nettype wire
